// ===== rtl/pu32_pkg.sv =====
// Shared types, constants and color helpers for the 1.5x pixel upscaler.
`default_nettype none

package pu32_pkg;

    // Source geometry; blocks are 2x2 source pixels
    localparam int SOURCE_WIDTH  = 160;
    localparam int SOURCE_HEIGHT = 144;
    localparam int BLOCK_COLS    = SOURCE_WIDTH / 2;
    localparam int BLOCK_ROWS    = SOURCE_HEIGHT / 2;
    localparam int BLOCK_COUNT   = BLOCK_COLS * BLOCK_ROWS;
    localparam int POS_W         = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Per-channel halving mask for exact averages
    localparam logic [23:0] HALF_MASK = 24'hFEFEFE;

    // Item function codes
    localparam logic FUNC_PIXEL   = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd4;

    typedef logic [23:0] rgb_t;
    typedef logic [1:0]  shade_t;

    typedef struct packed {
        logic       func;
        logic [7:0] src_top_left;
        logic [7:0] src_top_right;
        logic [7:0] src_bottom_left;
        logic [7:0] src_bottom_right;
    } pix_in_t;

    typedef struct packed {
        rgb_t out_top_left;
        rgb_t out_top_mid;
        rgb_t out_top_right;
        rgb_t out_mid_left;
        rgb_t out_centre;
        rgb_t out_mid_right;
        rgb_t out_bottom_left;
        rgb_t out_bottom_mid;
        rgb_t out_bottom_right;
        logic unchanged;
    } pix_out_t;

    // Classified block handed from front to back
    typedef struct packed {
        shade_t shade_tl;
        shade_t shade_tr;
        shade_t shade_bl;
        shade_t shade_br;
        logic   unchanged;
    } blk_t;

    // Exact per-channel average of two packed colors
    function automatic rgb_t avg_rgb(input rgb_t x, input rgb_t y);
        rgb_t half;
        half = ((x ^ y) & HALF_MASK) >> 1;
        return (x & y) + half;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pixel_upscale_3_over_2_core.sv =====
// 1.5x pixel upscaler top level: front end, queue and color back end.
//
// Usage:
//   pix channel: one beat per 2x2 source block, raster order of column pairs
//   within row pairs. func=0 is a pixel block; func=1 drops the previous
//   frame and restarts at frame start, and yields no result.
//   rgb channel: one beat per pixel block with the 3x3 colors and the
//   unchanged flag (block bytes equal to the same block of the last frame).
//   cfg channel: register writes (shades 0..3, smooth enable); always ready;
//   the user must write it only while the block is idle; no logic in the block enforces this.
//   A result passes the front-end stage, the queue and the output register.
//   Throughput: one block per cycle unless the receiver stalls, set by the
//   single read-before-write access of the previous-frame RAM per block.
//   Reset clears the position, the frame-valid flag, the palette and the
//   pipeline; the frame RAM is not cleared and is not compared until a
//   whole frame has been stored.
//   When the receiver stalls, the output register holds, the 4-entry queue
//   fills, and then pix_ready drops.
`default_nettype none

module pixel_upscale_3_over_2_core import pu32_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pix_valid,
    output logic                      pix_ready,
    input  wire pix_in_t              pix_data,
    output logic                      rgb_valid,
    input  wire logic                 rgb_ready,
    output pix_out_t                  rgb_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]          cfg_data
);

    logic push_valid;
    logic push_ready;
    blk_t push_data;
    logic pop_valid;
    logic pop_ready;
    blk_t pop_data;

    pu32_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_data   (pix_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pu32_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pu32_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb_data  (rgb_data)
    );

endmodule

`default_nettype wire

// ===== rtl/pu32_ram.sv =====
// Generic single-port RAM, read-before-write, registered read data.
`default_nettype none

module pu32_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same entry is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pu32_front.sv =====
// Front end: accepts source blocks, tracks position and frame, flags unchanged blocks.
`default_nettype none

module pu32_front import pu32_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pix_valid,
    output logic         pix_ready,
    input  wire pix_in_t pix_data,
    output logic         push_valid,
    input  wire logic    push_ready,
    output blk_t         push_data
);

    logic [POS_W-1:0] pos_reg;
    logic             prev_valid_reg;
    logic             s1_valid_reg;
    logic [31:0]      s1_packed_reg;
    logic             s1_pv_reg;

    logic             accept;
    logic             pixel_go;
    logic [31:0]      packed_in;
    logic [31:0]      ram_rdata;

    assign pix_ready = !s1_valid_reg || push_ready;
    assign accept    = pix_valid && pix_ready;
    assign pixel_go  = accept && (pix_data.func == FUNC_PIXEL);
    assign packed_in = {pix_data.src_bottom_right, pix_data.src_bottom_left,
                        pix_data.src_top_right, pix_data.src_top_left};

    // Previous frame store: read and rewrite the block's entry on a pixel accept
    pu32_ram #(
        .WIDTH (32),
        .DEPTH (BLOCK_COUNT)
    ) u_frame_ram (
        .clk   (clk),
        .we    (pixel_go),
        .re    (pixel_go),
        .addr  (pos_reg),
        .wdata (packed_in),
        .rdata (ram_rdata)
    );

    // Block position and frame-valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (pix_data.func == FUNC_RESTART)
            begin
                pos_reg        <= '0;
                prev_valid_reg <= 1'b0;
            end
            else if (pos_reg == POS_W'(BLOCK_COUNT - 1))
            begin
                pos_reg        <= '0;
                prev_valid_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // Stage waiting for the stored block to come back from the RAM
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            s1_valid_reg <= pixel_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_go)
        begin
            s1_packed_reg <= packed_in;
            s1_pv_reg     <= prev_valid_reg;
        end
    end

    // Classified block toward the queue
    assign push_valid          = s1_valid_reg;
    assign push_data.shade_tl  = s1_packed_reg[1:0];
    assign push_data.shade_tr  = s1_packed_reg[9:8];
    assign push_data.shade_bl  = s1_packed_reg[17:16];
    assign push_data.shade_br  = s1_packed_reg[25:24];
    assign push_data.unchanged = s1_pv_reg && (ram_rdata == s1_packed_reg);

endmodule

`default_nettype wire

// ===== rtl/pu32_queue.sv =====
// Short FIFO that decouples the front end from the color back end.
`default_nettype none

module pu32_queue import pu32_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire blk_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output blk_t      pop_data
);

    blk_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pu32_back.sv =====
// Back end: palette lookup, blending and the output register; holds the config registers.
`default_nettype none

module pu32_back import pu32_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]          cfg_data,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire blk_t                 pop_data,
    output logic                      rgb_valid,
    input  wire logic                 rgb_ready,
    output pix_out_t                  rgb_data
);

    rgb_t     palette_reg [4];
    logic     smooth_reg;
    logic     out_valid_reg;
    pix_out_t out_data_reg;
    pix_out_t out_next;

    rgb_t ctl;
    rgb_t ctr;
    rgb_t cbl;
    rgb_t cbr;
    rgb_t tmid;
    rgb_t bmid;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                palette_reg[i] <= '0;
            end
            smooth_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index) inside
                REG_SHADE0, REG_SHADE1, REG_SHADE2, REG_SHADE3:
                begin
                    palette_reg[cfg_index[1:0]] <= cfg_data;
                end
                REG_SMOOTH:
                begin
                    smooth_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Colors of the 3x3 output block
    always_comb
    begin
        ctl  = palette_reg[pop_data.shade_tl];
        ctr  = palette_reg[pop_data.shade_tr];
        cbl  = palette_reg[pop_data.shade_bl];
        cbr  = palette_reg[pop_data.shade_br];
        tmid = smooth_reg ? avg_rgb(ctl, ctr) : ctl;
        bmid = smooth_reg ? avg_rgb(cbl, cbr) : cbl;

        out_next.out_top_left     = ctl;
        out_next.out_top_mid      = tmid;
        out_next.out_top_right    = ctr;
        out_next.out_mid_left     = avg_rgb(ctl, cbl);
        out_next.out_centre       = avg_rgb(tmid, bmid);
        out_next.out_mid_right    = avg_rgb(ctr, cbr);
        out_next.out_bottom_left  = cbl;
        out_next.out_bottom_mid   = bmid;
        out_next.out_bottom_right = cbr;
        out_next.unchanged        = pop_data.unchanged;
    end

    // Output register
    assign pop_ready = !out_valid_reg || rgb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            out_data_reg <= out_next;
        end
    end

    assign rgb_valid = out_valid_reg;
    assign rgb_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pu32_checker.sv =====
// Port-level checks for the upscaler top level, bound to it.
`default_nettype none

module pu32_checker import pu32_pkg::*; (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     rgb_valid,
    input wire logic     rgb_ready,
    input wire pix_out_t rgb_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb_data))
        else $error("result beat changed while stalled");

    // Middle row is the average of top and bottom rows
    a_mid_left: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> rgb_data.out_mid_left ==
            avg_rgb(rgb_data.out_top_left, rgb_data.out_bottom_left))
        else $error("mid-left is not the top/bottom average");

    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> rgb_data.out_centre ==
            avg_rgb(rgb_data.out_top_mid, rgb_data.out_bottom_mid))
        else $error("centre is not the top/bottom average");

    a_mid_right: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> rgb_data.out_mid_right ==
            avg_rgb(rgb_data.out_top_right, rgb_data.out_bottom_right))
        else $error("mid-right is not the top/bottom average");

endmodule

bind pixel_upscale_3_over_2_core pu32_checker u_pu32_checker (.*);

`default_nettype wire
